// File: src/tbapr_pkg.sv
// shared types and constants of the time bin average and peak reducer
`default_nettype none
package tbapr_pkg;

    localparam int TIME_W   = 48;
    localparam int BIN_W    = 49;
    localparam int SIZE_W   = 40;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 48;
    localparam int CNT_W    = 16;
    localparam int CH_W     = 4;
    localparam int MAX_OUT  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;
    localparam int MUL_STEPS = SIZE_W;
    localparam int DIV_STEPS = BIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_GIVEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE  = 2'd3;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                    func;
        logic [TIME_W-1:0]       time_us;
        logic [CH_W-1:0]         channel;
        logic signed [VAL_W-1:0] sample_value;
    } t_in;

    typedef struct packed {
        logic [BIN_W-1:0]        bin_center_us;
        logic [CH_W-1:0]         out_channel;
        logic signed [VAL_W-1:0] average;
        logic signed [VAL_W-1:0] peak;
        logic                    empty_res;
        logic                    last;
    } t_out;

    typedef struct packed {
        logic [SIZE_W-1:0]       bin_size_us;
        logic [TIME_W-1:0]       start_time_us;
        logic                    start_given;
        logic signed [VAL_W-1:0] fill_value;
    } t_cfg;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] peak;
    } t_acc;

    typedef enum logic [3:0] {
        S_IDLE, S_BDIV_GO, S_BDIV, S_BCHK, S_MUL_GO, S_MUL,
        S_CRD, S_CCHK, S_ADIV, S_OUT, S_ARD, S_AUPD
    } t_state;

    typedef struct packed {
        logic latch;
        logic bdiv_start;
        logic bchk;
        logic mul_start;
        logic center_load;
        logic rd_k;
        logic avg_start;
        logic out_empty;
        logic out_avg;
        logic close;
        logic k_inc;
        logic set_bin;
        logic acc_write;
    } t_cmd;

    typedef struct packed {
        logic in_flush;
        logic in_ch_ok;
        logic bin_open;
        logic div_done;
        logic mul_done;
        logic bin_change;
        logic ch_empty;
        logic out_taken;
        logic k_last;
        logic emit_last;
    } t_stat;

endpackage
`default_nettype wire

// File: src/time_bin_avg_peak_reducer.sv
// top level of the time bin average and peak reducer
// Accepts one request at a time; o_in_stall is high while a request is worked.
// A sample for an existing channel goes through a 49-step bin divider, then a RAM
// read-modify-write of the channel's sum, count and peak, before the next acceptance.
// A sample that opens a new bin while one is open, or a flush of an open bin, first
// emits one result per channel: the bin center (40 serial shift-add steps), then per
// channel a RAM read and, for a non-empty channel, a 49-step averaging division;
// an output stall holds each result. One shared restoring divider serves both divisions.
// Channel sums are cleared at once by per-channel valid flops, so no clearing
// pass is needed.
`default_nettype none
module time_bin_avg_peak_reducer
    import tbapr_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // sample and flush requests
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in                  i_in_data,
    // per-channel results
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out                      o_out_data,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);
    localparam int OUT_CH = CHANNELS < MAX_OUT ? CHANNELS : MAX_OUT;

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  busy;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bin_size_us   <= SIZE_W'(1000000);
            r_cfg.start_time_us <= '0;
            r_cfg.start_given   <= 1'b0;
            r_cfg.fill_value    <= {1'b1, {(VAL_W-1){1'b0}}};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BIN_SIZE:    r_cfg.bin_size_us   <= i_cfg_data[SIZE_W-1:0];
                CFG_START_TIME:  r_cfg.start_time_us <= i_cfg_data[TIME_W-1:0];
                CFG_START_GIVEN: r_cfg.start_given   <= i_cfg_data[0];
                CFG_FILL_VALUE:  r_cfg.fill_value    <= i_cfg_data[VAL_W-1:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    tbapr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    tbapr_dpath #(.CHANNELS(CHANNELS)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

    // one request in flight
    assign o_in_stall = busy;

    a_out_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result pending while idle");
    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> (o_out_data.out_channel == CH_W'(OUT_CH - 1)))
        else $error("last flag on wrong channel");
    a_gap_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.out_channel != CH_W'(OUT_CH - 1))
        |=> !o_out_valid)
        else $error("results issued without a read cycle");
endmodule
`default_nettype wire

// File: src/tbapr_ram.sv
// generic single port write, registered read ram
`default_nettype none
module tbapr_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                   i_wdata,
    input  wire logic                           i_re,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic      [W-1:0]                   o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: src/tbapr_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module tbapr_div
    import tbapr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [BIN_W-1:0]  i_dividend,
    input  wire logic [SIZE_W-1:0] i_divisor,
    output logic      [BIN_W-1:0]  o_quotient,
    output logic                   o_done
);
    logic [BIN_W-1:0]  r_quo;
    logic [SIZE_W:0]   r_rem;
    logic [SIZE_W-1:0] r_div;
    logic [5:0]        r_cnt;
    logic              r_run;
    logic              r_done;
    logic [SIZE_W:0]   n_trial;
    logic              n_ge;

    always_comb begin
        n_trial = {r_rem[SIZE_W-1:0], r_quo[BIN_W-1]};
        n_ge    = n_trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 6'(DIV_STEPS);
        end else if (r_run) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_rem <= n_ge ? n_trial - {1'b0, r_div} : n_trial;
            r_quo <= {r_quo[BIN_W-2:0], n_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;
endmodule
`default_nettype wire

// File: src/tbapr_ctrl.sv
// controller state machine sequencing bin division, emission and accumulation
`default_nettype none
module tbapr_ctrl
    import tbapr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);
    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign o_busy = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.in_flush) begin
                        n_state = i_stat.bin_open ? S_MUL_GO : S_IDLE;
                    end else begin
                        n_state = i_stat.in_ch_ok ? S_BDIV_GO : S_IDLE;
                    end
                end
            end
            S_BDIV_GO: n_state = S_BDIV;
            S_BDIV:    if (i_stat.div_done) n_state = S_BCHK;
            S_BCHK:    n_state = i_stat.bin_change ? S_MUL_GO : S_ARD;
            S_MUL_GO:  n_state = S_MUL;
            S_MUL:     if (i_stat.mul_done) n_state = S_CRD;
            S_CRD:     n_state = S_CCHK;
            S_CCHK:    n_state = i_stat.ch_empty ? S_OUT : S_ADIV;
            S_ADIV:    if (i_stat.div_done) n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_taken) begin
                    if (i_stat.k_last) begin
                        n_state = i_stat.emit_last ? S_IDLE : S_ARD;
                    end else begin
                        n_state = S_CRD;
                    end
                end
            end
            S_ARD:  n_state = S_AUPD;
            S_AUPD: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:    o_cmd.latch = accept;
            S_BDIV_GO: o_cmd.bdiv_start = 1'b1;
            S_BCHK:    o_cmd.bchk = 1'b1;
            S_MUL_GO:  o_cmd.mul_start = 1'b1;
            S_MUL:     o_cmd.center_load = i_stat.mul_done;
            S_CRD:     o_cmd.rd_k = 1'b1;
            S_CCHK: begin
                o_cmd.out_empty = i_stat.ch_empty;
                o_cmd.avg_start = !i_stat.ch_empty;
            end
            S_ADIV:    o_cmd.out_avg = i_stat.div_done;
            S_OUT: begin
                o_cmd.close = i_stat.out_taken && i_stat.k_last;
                o_cmd.k_inc = i_stat.out_taken && !i_stat.k_last;
            end
            S_ARD:     o_cmd.set_bin = 1'b1;
            S_AUPD:    o_cmd.acc_write = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

    a_one_div_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.bdiv_start && o_cmd.avg_start))
        else $error("two divider starts at once");
    a_close_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.close |=> (r_state == S_IDLE || r_state == S_ARD))
        else $error("bad state after closing a bin");
    a_mul_after_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_GO) |=> (r_state == S_MUL))
        else $error("multiply not started");
endmodule
`default_nettype wire

// File: src/tbapr_dpath.sv
// datapath: bin arithmetic, channel accumulators and result register
`default_nettype none
module tbapr_dpath
    import tbapr_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire t_in  i_in,
    input  wire t_cmd i_cmd,
    input  wire logic i_out_stall,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out      o_out
);
    localparam int AW     = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
    localparam int OUT_CH = CHANNELS < MAX_OUT ? CHANNELS : MAX_OUT;
    localparam int ACC_W  = $bits(t_acc);

    t_in               r_in;
    logic              r_start_known;
    logic [TIME_W-1:0] r_learned;
    logic              r_bin_open;
    logic [BIN_W-1:0]  r_cur_bin;
    logic [BIN_W-1:0]  r_new_bin;
    logic              r_neg;
    logic [CHANNELS-1:0] r_valid;
    logic              r_rd_valid;
    logic [AW-1:0]     r_rd_addr;
    logic [CH_W-1:0]   r_k;
    logic [BIN_W-1:0]  r_center;
    logic [BIN_W-1:0]  r_mul_acc;
    logic [BIN_W-1:0]  r_mul_a;
    logic [SIZE_W-1:0] r_mul_b;
    logic [5:0]        r_mul_cnt;
    logic              r_mul_done;
    logic              r_out_valid;
    t_out              r_out;

    logic [SIZE_W-1:0] eff_size;
    logic [TIME_W-1:0] eff_start;
    logic [BIN_W-1:0]  diff;
    logic [BIN_W-1:0]  bin_mag;
    logic [BIN_W-1:0]  quo;
    logic [BIN_W-1:0]  q_signed;
    logic              div_done;
    logic              div_start;
    logic [BIN_W-1:0]  div_dividend;
    logic [SIZE_W-1:0] div_divisor;
    logic [SUM_W-1:0]  sum_mag;
    logic [AW+CH_W-1:0] ch_ext;
    logic [AW+CH_W-1:0] k_ext;
    logic [AW-1:0]     raddr;
    logic              re;
    logic [ACC_W-1:0]  rdata;
    t_acc              acc_eff;
    t_acc              acc_new;
    logic signed [VAL_W-1:0] avg;
    logic              last_flag;

    assign eff_size  = (i_cfg.bin_size_us == '0) ? SIZE_W'(1) : i_cfg.bin_size_us;
    assign eff_start = i_cfg.start_given ? i_cfg.start_time_us : r_learned;
    assign diff      = {1'b0, r_in.time_us} - {1'b0, eff_start};
    assign bin_mag   = diff[BIN_W-1] ? -diff : diff;
    assign q_signed  = r_neg ? -quo : quo;
    assign acc_eff   = r_rd_valid ? t_acc'(rdata) : '0;
    assign sum_mag   = acc_eff.sum[SUM_W-1] ? -acc_eff.sum : acc_eff.sum;
    assign avg       = r_neg ? -quo[VAL_W-1:0] : quo[VAL_W-1:0];
    assign last_flag = r_in.func && (r_k == CH_W'(OUT_CH - 1));

    assign ch_ext = {{AW{1'b0}}, r_in.channel};
    assign k_ext  = {{AW{1'b0}}, r_k};
    assign re     = i_cmd.rd_k || i_cmd.set_bin;
    assign raddr  = i_cmd.rd_k ? k_ext[AW-1:0] : ch_ext[AW-1:0];

    assign div_start    = i_cmd.bdiv_start || i_cmd.avg_start;
    assign div_dividend = i_cmd.bdiv_start ? bin_mag : {1'b0, sum_mag};
    assign div_divisor  = i_cmd.bdiv_start ? eff_size : {{(SIZE_W-CNT_W){1'b0}}, acc_eff.count};

    tbapr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    tbapr_ram #(.W(ACC_W), .D(CHANNELS)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acc_write && (r_in.sample_value != i_cfg.fill_value)),
        .i_waddr (r_rd_addr),
        .i_wdata (acc_new),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // accumulate one non-fill sample, peak first, count saturates
    always_comb begin
        acc_new = acc_eff;
        if (acc_eff.count == '0 || r_in.sample_value > acc_eff.peak) begin
            acc_new.peak = r_in.sample_value;
        end
        if (acc_eff.count != COUNT_MAX) begin
            acc_new.sum   = acc_eff.sum + SUM_W'(r_in.sample_value);
            acc_new.count = acc_eff.count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_known <= 1'b0;
            r_learned     <= '0;
            r_bin_open    <= 1'b0;
            r_cur_bin     <= '0;
            r_valid       <= '0;
            r_mul_done    <= 1'b0;
            r_mul_cnt     <= '0;
            r_out_valid   <= 1'b0;
            r_k           <= '0;
        end else begin
            if (i_cmd.latch && i_in.func == FUNC_SAMPLE && o_stat.in_ch_ok
                    && !i_cfg.start_given && !r_start_known) begin
                r_start_known <= 1'b1;
                r_learned     <= i_in.time_us;
            end
            if (i_cmd.mul_start) begin
                r_mul_cnt  <= 6'(MUL_STEPS);
                r_mul_done <= 1'b0;
            end else if (r_mul_cnt != '0) begin
                r_mul_cnt <= r_mul_cnt - 6'd1;
                if (r_mul_cnt == 6'd1) begin
                    r_mul_done <= 1'b1;
                end
            end
            if (i_cmd.center_load) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + CH_W'(1);
            end
            if (i_cmd.close) begin
                r_valid    <= '0;
                r_bin_open <= 1'b0;
                r_cur_bin  <= '0;
            end else if (i_cmd.set_bin) begin
                r_bin_open <= 1'b1;
                r_cur_bin  <= r_new_bin;
            end
            if (i_cmd.acc_write && r_in.sample_value != i_cfg.fill_value) begin
                r_valid[r_rd_addr] <= 1'b1;
            end
            if (i_cmd.out_empty || i_cmd.out_avg) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in <= i_in;
        end
        if (i_cmd.bdiv_start) begin
            r_neg <= diff[BIN_W-1];
        end else if (i_cmd.avg_start) begin
            r_neg <= acc_eff.sum[SUM_W-1];
        end
        if (i_cmd.bchk) begin
            r_new_bin <= q_signed;
        end
        if (re) begin
            r_rd_addr  <= raddr;
            r_rd_valid <= r_valid[raddr];
        end
        // serial shift-add product of bin number and size
        if (i_cmd.mul_start) begin
            r_mul_acc <= '0;
            r_mul_a   <= r_cur_bin;
            r_mul_b   <= eff_size;
        end else if (r_mul_cnt != '0) begin
            if (r_mul_b[0]) begin
                r_mul_acc <= r_mul_acc + r_mul_a;
            end
            r_mul_a <= {r_mul_a[BIN_W-2:0], 1'b0};
            r_mul_b <= {1'b0, r_mul_b[SIZE_W-1:1]};
        end
        if (i_cmd.center_load) begin
            r_center <= {1'b0, eff_start} + r_mul_acc
                        + {{(BIN_W-SIZE_W+1){1'b0}}, eff_size[SIZE_W-1:1]};
        end
        if (i_cmd.out_empty) begin
            r_out <= '{bin_center_us: r_center, out_channel: r_k,
                       average: i_cfg.fill_value, peak: i_cfg.fill_value,
                       empty_res: 1'b1, last: last_flag};
        end else if (i_cmd.out_avg) begin
            r_out <= '{bin_center_us: r_center, out_channel: r_k,
                       average: avg, peak: acc_eff.peak,
                       empty_res: 1'b0, last: last_flag};
        end
    end

    always_comb begin
        o_stat.in_flush   = i_in.func == FUNC_FLUSH;
        o_stat.in_ch_ok   = 32'(i_in.channel) < CHANNELS;
        o_stat.bin_open   = r_bin_open;
        o_stat.div_done   = div_done;
        o_stat.mul_done   = r_mul_done;
        o_stat.bin_change = r_bin_open && (q_signed != r_cur_bin);
        o_stat.ch_empty   = acc_eff.count == '0;
        o_stat.out_taken  = r_out_valid && !i_out_stall;
        o_stat.k_last     = r_k == CH_W'(OUT_CH - 1);
        o_stat.emit_last  = r_in.func;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule
`default_nettype wire

// File: sim/tb_time_bin_avg_peak_reducer.sv
// testbench of the time bin average and peak reducer with its own predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_time_bin_avg_peak_reducer;
    import tbapr_pkg::*;

    localparam int  NCH        = 16;
    localparam int  IDLE_PCT   = 24;
    // a sample can still be in its read-modify-write when the last result left
    localparam int  TAIL_WAIT  = 150;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in                  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BIN_SIZE;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    time_bin_avg_peak_reducer #(.CHANNELS(NCH)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // requests waiting to be driven and channel results still owed
    t_in    pending_req[$];
    t_out   owed_result[$];
    int     errs = 0;
    bit     quiet = 1'b0;        // no idling on either side while set
    bit     req_taken = 1'b0;
    longint cycles = 0;

    // predictor copy of configuration and bin state
    logic [SIZE_W-1:0]       bin_size;
    logic [TIME_W-1:0]       start_time;
    logic                    start_given;
    logic signed [VAL_W-1:0] fill;
    bit                      start_known;
    logic [TIME_W-1:0]       learned_start;
    bit                      bin_open;
    longint                  open_bin;
    longint                  ch_sum [NCH];
    int unsigned             ch_count [NCH];
    logic signed [VAL_W-1:0] ch_peak [NCH];

    function automatic longint eff_size();
        return (bin_size == '0) ? 64'sd1 : longint'({24'b0, bin_size});
    endfunction

    function automatic longint eff_start();
        return longint'({16'b0, (start_given ? start_time : learned_start)});
    endfunction

    // close the open bin: one result per channel, then clear the accumulators
    function automatic void close_bin(bit mark_last);
        longint sz;
        longint ctr;
        t_out   r;
        sz  = eff_size();
        ctr = eff_start() + open_bin * sz + sz / 2;
        for (int k = 0; k < NCH; k++) begin
            r.bin_center_us = ctr[BIN_W-1:0];
            r.out_channel   = k[CH_W-1:0];
            r.empty_res     = (ch_count[k] == 0);
            if (ch_count[k] == 0) begin
                r.average = fill;
                r.peak    = fill;
            end else begin
                r.average = VAL_W'(ch_sum[k] / longint'(ch_count[k]));
                r.peak    = ch_peak[k];
            end
            r.last = mark_last && (k == NCH - 1);
            owed_result.push_back(r);
            ch_sum[k]   = 0;
            ch_count[k] = 0;
            ch_peak[k]  = '0;
        end
        bin_open = 1'b0;
        open_bin = 0;
    endfunction

    function automatic void predict(t_in q);
        longint b;
        int     c;
        if (q.func == FUNC_FLUSH) begin
            if (bin_open) close_bin(1'b1);
            return;
        end
        c = int'(q.channel);
        if (!start_given && !start_known) begin
            learned_start = q.time_us;
            start_known   = 1'b1;
        end
        b = (longint'({16'b0, q.time_us}) - eff_start()) / eff_size();
        if (bin_open && b != open_bin) close_bin(1'b0);
        open_bin = b;
        bin_open = 1'b1;
        // fill samples still move the bin but are never accumulated
        if (q.sample_value != fill) begin
            if (ch_count[c] == 0 || q.sample_value > ch_peak[c]) ch_peak[c] = q.sample_value;
            if (ch_count[c] < 65535) begin
                ch_sum[c]   += longint'(q.sample_value);
                ch_count[c] += 1;
            end
        end
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
        case (idx)
            CFG_BIN_SIZE:    bin_size    = d[SIZE_W-1:0];
            CFG_START_TIME:  start_time  = d[TIME_W-1:0];
            CFG_START_GIVEN: start_given = d[0];
            CFG_FILL_VALUE:  fill        = d[VAL_W-1:0];
            default: ;
        endcase
    endfunction

    // accept side: predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        t_out e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        req_taken = in_valid && !in_stall;
        if (i_rst_n && req_taken) predict(in_data);
        if (i_rst_n && out_valid && !out_stall) begin
            if (owed_result.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, out_data);
                errs++;
            end else begin
                e = owed_result.pop_front();
                if (out_data !== e) begin
                    $display("%0t: result mismatch ctr %h ch %0d avg %0d pk %0d emp %b last %b",
                             $time, e.bin_center_us, e.out_channel, e.average, e.peak,
                             e.empty_res, e.last);
                    $display("%0t:   actual     ctr %h ch %0d avg %0d pk %0d emp %b last %b",
                             $time, out_data.bin_center_us, out_data.out_channel,
                             out_data.average, out_data.peak, out_data.empty_res,
                             out_data.last);
                    errs++;
                end
            end
        end
    end

    // request driver: holds a stalled request, otherwise loads the next one or idles
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || req_taken)) begin
            if (pending_req.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                in_data  <= pending_req.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    function automatic void push_sample(logic [TIME_W-1:0] t, int ch, logic [VAL_W-1:0] v);
        t_in q;
        q.func         = FUNC_SAMPLE;
        q.time_us      = t;
        q.channel      = ch[CH_W-1:0];
        q.sample_value = v;
        pending_req.push_back(q);
    endfunction

    // flush fields are don't-care, so they carry random junk
    function automatic void push_flush();
        t_in q;
        q.func         = FUNC_FLUSH;
        q.time_us      = TIME_W'({$urandom, $urandom});
        q.channel      = CH_W'($urandom);
        q.sample_value = $urandom;
        pending_req.push_back(q);
    endfunction

    // mostly well-formed streams of rising time with random content, some noise
    function automatic void push_burst(int n, logic [TIME_W-1:0] base, int unsigned step);
        logic [TIME_W-1:0] t;
        logic [VAL_W-1:0]  v;
        int                r;
        t = base;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 6) begin
                push_flush();
            end else begin
                case ($urandom_range(9))
                    0:       v = fill;
                    1:       v = 32'h7fffffff;
                    2:       v = 32'h80000000;
                    3, 4:    v = VAL_W'($signed($urandom_range(200)) - 100);
                    default: v = $urandom;
                endcase
                if (r < 14) begin
                    push_sample(TIME_W'({$urandom, $urandom}), $urandom_range(NCH - 1), v);
                end else begin
                    push_sample(t, $urandom_range(NCH - 1), v);
                    t = t + TIME_W'($urandom_range(step));
                end
            end
        end
        push_flush();
    endfunction

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        apply_cfg(idx, d);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // sender pauses here until every owed result came and the block went quiet
    task automatic drain();
        @(posedge i_clk);
        while (pending_req.size() != 0 || in_valid || owed_result.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    initial begin
        bin_size      = SIZE_W'(1000000);
        start_time    = '0;
        start_given   = 1'b0;
        fill          = 32'h80000000;
        start_known   = 1'b0;
        learned_start = '0;
        bin_open      = 1'b0;
        open_bin      = 0;
        for (int k = 0; k < NCH; k++) begin
            ch_sum[k]   = 0;
            ch_count[k] = 0;
            ch_peak[k]  = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, start learned from first sample
        push_flush();                                  // flush with no open bin
        push_sample(48'd1000, 0, 32'h7fffffff);
        push_sample(48'd1500, 15, 32'h80000000);       // fill sample, still opens nothing new
        push_sample(48'd2000, 3, 32'h80000001);
        push_sample(48'd2100, 3, 32'hfffffff0);        // peak update in same bin
        push_sample(48'd3000, 0, 32'h00000005);
        push_sample(48'd1001000, 7, 32'h12345678);     // next bin, emits previous
        push_sample(48'd500, 2, 32'h00000001);         // time before start, bin toward zero
        push_sample(TIME_MAX, 15, 32'h00000002);
        push_flush();
        push_flush();
        drain();
        push_burst(80, 48'd5000, 300000);
        drain();

        // zero size acts as one, given start, zero fill, negative bins
        write_cfg(CFG_BIN_SIZE, '0);
        write_cfg(CFG_START_TIME, 48'd100);
        write_cfg(CFG_START_GIVEN, 48'd1);
        write_cfg(CFG_FILL_VALUE, {16'hbeef, 32'h00000000});
        push_burst(70, 48'd90, 2);
        drain();

        // largest size and start, largest fill
        write_cfg(CFG_BIN_SIZE, {8'h00, 40'hffffffffff});
        write_cfg(CFG_START_TIME, TIME_MAX);
        write_cfg(CFG_FILL_VALUE, {16'h0000, 32'h7fffffff});
        push_sample('0, 1, 32'h00000009);
        push_sample(TIME_MAX, 1, 32'h00000003);
        push_burst(60, TIME_MAX - 48'h20000000000, 32'hffffffff);
        drain();

        // start learning switched back on after one was learned
        write_cfg(CFG_START_GIVEN, '0);
        write_cfg(CFG_BIN_SIZE, 48'd37);
        write_cfg(CFG_FILL_VALUE, {16'hffff, 32'hfffffffb});
        push_burst(50, 48'd20000, 15);
        drain();
        push_burst(50, 48'd30000, 15);
        drain();

        // long stretch with no idling at all, then one with random idling
        write_cfg(CFG_BIN_SIZE, 48'd1000);
        write_cfg(CFG_START_TIME, '0);
        write_cfg(CFG_START_GIVEN, 48'd1);
        write_cfg(CFG_FILL_VALUE, {16'h1234, 32'h80000000});
        quiet = 1'b1;
        push_burst(60, 48'd777, 400);
        drain();
        quiet = 1'b0;
        push_burst(60, 48'd123456, 400);
        drain();

        if (errs == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
src/tbapr_pkg.sv
src/tbapr_ram.sv
src/tbapr_div.sv
src/tbapr_ctrl.sv
src/tbapr_dpath.sv
src/time_bin_avg_peak_reducer.sv
sim/tb_time_bin_avg_peak_reducer.sv
